// ----- design/lfpq_pkg.sv -----
// Shared types, constants and key compare function for the lexicographic priority queue.
package lfpq_pkg;

   localparam int CAPACITY    = 64;
   localparam int KEY_FIELDS  = 3;
   localparam int KEY_WIDTH   = 16;
   localparam int ENTRY_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_PEEK   = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   localparam logic [1:0] OP_HOLD       = 2'd0;
   localparam logic [1:0] OP_TAKE_NEW   = 2'd1;
   localparam logic [1:0] OP_TAKE_LEFT  = 2'd2;
   localparam logic [1:0] OP_TAKE_RIGHT = 2'd3;

   typedef logic [KEY_FIELDS-1:0][KEY_WIDTH-1:0] key_set_type;

   typedef struct packed {
      logic [ENTRY_WIDTH-1:0] entry;
      key_set_type            keys;
   } cell_data_type;

   typedef struct packed {
      logic       cmp_en;
      logic [1:0] op;
   } cell_ctrl_type;

   // True when stored key a orders strictly after new key b over the first n components.
   function automatic logic key_greater(key_set_type a, key_set_type b, logic [1:0] n);
      logic gt0, gt1, gt2, eq0, eq1;
      gt0 = a[0] > b[0];
      gt1 = a[1] > b[1];
      gt2 = a[2] > b[2];
      eq0 = a[0] == b[0];
      eq1 = a[1] == b[1];
      return gt0 | (eq0 & (n >= 2'd2) & (gt1 | (eq1 & (n >= 2'd3) & gt2)));
   endfunction

endpackage

// ----- design/lfpq_cell.sv -----
// One storage cell of the sorted chain: payload, keys and a registered compare flag.
module lfpq_cell (
   input  logic                   clock,
   input  lfpq_pkg::cell_ctrl_type ctrl,
   input  logic [1:0]             used_keys,
   input  lfpq_pkg::key_set_type  cmp_keys,
   input  lfpq_pkg::cell_data_type new_data,
   input  lfpq_pkg::cell_data_type left_data,
   input  lfpq_pkg::cell_data_type right_data,
   output lfpq_pkg::cell_data_type data,
   output logic                   greater
);
   import lfpq_pkg::*;

   cell_data_type data_ff, data_in;
   logic          greater_ff;

   always_comb begin
      case (ctrl.op)
         OP_TAKE_NEW:   data_in = new_data;
         OP_TAKE_LEFT:  data_in = left_data;
         OP_TAKE_RIGHT: data_in = right_data;
         default:       data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (ctrl.cmp_en) begin
         greater_ff <= key_greater(data_ff.keys, cmp_keys, used_keys);
      end
   end

   assign data    = data_ff;
   assign greater = greater_ff;

endmodule

// ----- design/lexicographic_fifo_priority_queue.sv -----
// Top level of the lexicographic priority queue built as a sorted chain of cells.
//
// Usage: one request on the req_ channel carries an action (insert, remove
// minimum, peek minimum, clear) with a payload and three key values. Each
// request yields exactly one response on the rsp_ channel with the minimum's
// payload and keys (remove and peek), a status, the count afterwards and an
// empty flag. A transfer happens when valid is high and stall is low.
// In the transfer cycle every cell compares its stored key with the new key
// and registers the result; in the execute state, once the response register
// is free, the chain shifts (insert right of the slot, remove left) and the
// response register is loaded. One request is worked on at a time. If
// rsp_stall holds a previous response, the next request waits in the execute
// state until the response register frees up; req_stall stays high.
// csr_write_enable writes the key count register (reset 1); the user must do
// so only while idle, as the block does not enforce it.
// Reset (synchronous) empties the queue and clears the response channel.
module lexicographic_fifo_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_entry,
   input  logic [15:0] req_key_first,
   input  logic [15:0] req_key_second,
   input  logic [15:0] req_key_third,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_entry,
   output logic [15:0] rsp_out_key_first,
   output logic [15:0] rsp_out_key_second,
   output logic [15:0] rsp_out_key_third,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_count_now,
   output logic        rsp_is_empty
);
   import lfpq_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                   state_ff, state_in;
   logic [1:0]             key_count_ff;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]             action_ff;
   cell_data_type          new_data_ff;
   key_set_type            cmp_keys;
   logic [1:0]             used_keys;
   logic                   req_xfer, exec_go, full, empty;

   cell_ctrl_type          ctrl [CAPACITY];
   cell_data_type          cell_data [CAPACITY];
   logic [CAPACITY-1:0]    greater, hit;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_WIDTH-1:0] rsp_entry_ff, rsp_entry_in;
   key_set_type            rsp_keys_ff, rsp_keys_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   assign req_stall = state_ff != ST_IDLE;
   assign req_xfer  = req_valid & ~req_stall;
   assign exec_go   = (state_ff == ST_EXEC) & (~rsp_valid_ff | ~rsp_stall);
   assign used_keys = (key_count_ff == 2'd0) ? 2'd1 : key_count_ff;
   assign full      = count_ff == COUNT_WIDTH'(CAPACITY);
   assign empty     = count_ff == '0;

   assign cmp_keys[0] = req_key_first;
   assign cmp_keys[1] = req_key_second;
   assign cmp_keys[2] = req_key_third;

   // Per-cell shift control; slot search is a prefix OR over valid hits.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         hit[i] = greater[i] & (COUNT_WIDTH'(i) < count_ff);
      end
      for (int i = 0; i < CAPACITY; i++) begin
         ctrl[i].cmp_en = req_xfer;
         ctrl[i].op     = OP_HOLD;
         if (exec_go) begin
            if (action_ff == ACT_INSERT && !full) begin
               if ((hit & ((CAPACITY)'(1) << i) - (CAPACITY)'(1)) != '0) begin
                  ctrl[i].op = OP_TAKE_LEFT;
               end else if (hit[i] || COUNT_WIDTH'(i) == count_ff) begin
                  ctrl[i].op = OP_TAKE_NEW;
               end
            end else if (action_ff == ACT_REMOVE && !empty) begin
               ctrl[i].op = OP_TAKE_RIGHT;
            end
         end
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      lfpq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[g]),
         .used_keys  (used_keys),
         .cmp_keys   (cmp_keys),
         .new_data   (new_data_ff),
         .left_data  ((g == 0) ? new_data_ff : cell_data[(g == 0) ? 0 : g - 1]),
         .right_data (cell_data[(g == CAPACITY - 1) ? g : g + 1]),
         .data       (cell_data[g]),
         .greater    (greater[g])
      );
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_entry_in  = rsp_entry_ff;
      rsp_keys_in   = rsp_keys_ff;
      rsp_status_in = rsp_status_ff;
      if (req_xfer) begin
         state_in = ST_EXEC;
      end
      if (exec_go) begin
         state_in      = ST_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_entry_in  = '0;
         rsp_keys_in   = '0;
         rsp_status_in = STAT_OK;
         case (action_ff)
            ACT_INSERT: begin
               if (full) rsp_status_in = STAT_FULL;
               else      count_in = count_ff + COUNT_WIDTH'(1);
            end
            ACT_REMOVE, ACT_PEEK: begin
               if (empty) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  rsp_entry_in   = cell_data[0].entry;
                  rsp_keys_in[0] = cell_data[0].keys[0];
                  if (used_keys >= 2'd2) rsp_keys_in[1] = cell_data[0].keys[1];
                  if (used_keys >= 2'd3) rsp_keys_in[2] = cell_data[0].keys[2];
                  if (action_ff == ACT_REMOVE) count_in = count_ff - COUNT_WIDTH'(1);
               end
            end
            default: count_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         key_count_ff <= 2'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) key_count_ff <= csr_write_data;
      end
      if (req_xfer) begin
         action_ff            <= req_action;
         new_data_ff.entry    <= req_entry;
         new_data_ff.keys     <= cmp_keys;
      end
      rsp_entry_ff  <= rsp_entry_in;
      rsp_keys_ff   <= rsp_keys_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_entry      = rsp_entry_ff;
   assign rsp_out_key_first  = rsp_keys_ff[0];
   assign rsp_out_key_second = rsp_keys_ff[1];
   assign rsp_out_key_third  = rsp_keys_ff[2];
   assign rsp_status         = rsp_status_ff;
   assign rsp_count_now      = count_ff;
   assign rsp_is_empty       = empty;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(CAPACITY))
      else $error("stored count above capacity");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_EXEC)
      else $error("accepted request did not move to execute");

   a_exec_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("execute cycle did not load a response");

   a_status_count: assert property (@(posedge clock) disable iff (reset)
      exec_go && action_ff == ACT_REMOVE && !empty |=> count_ff == $past(count_ff) - 7'd1)
      else $error("remove did not decrement count");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the lexicographic priority queue with FIFO tie-break.
module tb_top;
   import lfpq_pkg::*;

   localparam int TIMEOUT_CYCLES = 400_000;

   typedef struct packed {
      logic [31:0]      entry;
      logic [2:0][15:0] keys;   // keys[0] is the most significant component
   } stored_cell_type;

   typedef struct packed {
      logic [31:0] entry;
      logic [15:0] key_first;
      logic [15:0] key_second;
      logic [15:0] key_third;
      logic [1:0]  status;
      logic [6:0]  count_now;
      logic        is_empty;
   } queue_result_type;

   // Sorted copy of the queue contents plus the responses still owed by the block.
   class queue_mirror;
      stored_cell_type  cells[$];
      queue_result_type pending_results[$];
      logic [1:0]       key_count;
      int unsigned      mismatches;

      function new();
         key_count  = 2'd1;
         mismatches = 0;
      endfunction

      function int unsigned key_depth();
         return (key_count == 2'd0) ? 1 : key_count;
      endfunction

      // Stored key orders strictly after the new key over the active components.
      function bit orders_after(stored_cell_type stored, logic [2:0][15:0] fresh);
         int unsigned n;
         int unsigned i;
         n = key_depth();
         for (i = 0; i < n; i++) begin
            if (stored.keys[i] > fresh[i]) return 1'b1;
            if (stored.keys[i] < fresh[i]) return 1'b0;
         end
         return 1'b0;
      endfunction

      function void log_failure(string msg);
         mismatches++;
         if (mismatches <= 10) $display("ERROR @%0t: %s", $time, msg);
      endfunction

      function void note_request(logic [1:0] action, logic [31:0] entry,
                                 logic [15:0] key_a, logic [15:0] key_b,
                                 logic [15:0] key_c);
         queue_result_type r;
         stored_cell_type  c;
         int unsigned      pos;
         int unsigned      sz;
         int unsigned      i;
         r        = '0;
         r.status = STAT_OK;
         sz       = cells.size();
         case (action)
            ACT_INSERT: begin
               if (sz >= CAPACITY) begin
                  r.status = STAT_FULL;
               end else begin
                  c.entry = entry;
                  c.keys  = {key_c, key_b, key_a};
                  // land behind every entry that does not order after the new one
                  pos = sz;
                  for (i = 0; i < sz; i++)
                     if (pos == sz && orders_after(cells[i], c.keys)) pos = i;
                  cells.insert(pos, c);
               end
            end
            ACT_REMOVE, ACT_PEEK: begin
               if (sz == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  c           = cells[0];
                  r.entry     = c.entry;
                  r.key_first = c.keys[0];
                  if (key_depth() >= 2) r.key_second = c.keys[1];
                  if (key_depth() >= 3) r.key_third = c.keys[2];
                  if (action == ACT_REMOVE) cells.delete(0);
               end
            end
            ACT_CLEAR: cells.delete();
            default: ;
         endcase
         r.count_now = 7'(cells.size());
         r.is_empty  = (cells.size() == 0);
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void check_response(queue_result_type got);
         queue_result_type want;
         if (pending_results.size() == 0) begin
            log_failure($sformatf("response with nothing outstanding: %p", got));
            return;
         end
         want = pending_results[0];
         pending_results.delete(0);
         if (got.entry !== want.entry || got.key_first !== want.key_first ||
             got.key_second !== want.key_second || got.key_third !== want.key_third ||
             got.status !== want.status || got.count_now !== want.count_now ||
             got.is_empty !== want.is_empty)
            log_failure($sformatf("response mismatch\n  expected %p\n  actual   %p",
                                  want, got));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_write_data = 2'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_INSERT;
   logic [31:0] req_entry = 32'd0;
   logic [15:0] req_key_first = 16'd0;
   logic [15:0] req_key_second = 16'd0;
   logic [15:0] req_key_third = 16'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_out_entry;
   logic [15:0] rsp_out_key_first;
   logic [15:0] rsp_out_key_second;
   logic [15:0] rsp_out_key_third;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_count_now;
   logic        rsp_is_empty;

   queue_mirror mirror = new();

   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned stall_left = 0;
   bit          calm = 1'b0;

   lexicographic_fifo_priority_queue DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_entry          (req_entry),
      .req_key_first      (req_key_first),
      .req_key_second     (req_key_second),
      .req_key_third      (req_key_third),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_entry      (rsp_out_entry),
      .rsp_out_key_first  (rsp_out_key_first),
      .rsp_out_key_second (rsp_out_key_second),
      .rsp_out_key_third  (rsp_out_key_third),
      .rsp_status         (rsp_status),
      .rsp_count_now      (rsp_count_now),
      .rsp_is_empty       (rsp_is_empty)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Response back-pressure applied in bursts at random.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         mirror.check_response({rsp_out_entry, rsp_out_key_first, rsp_out_key_second,
                                rsp_out_key_third, rsp_status, rsp_count_now, rsp_is_empty});
   end

   task automatic send_req(logic [1:0] action, logic [31:0] entry,
                           logic [15:0] key_a, logic [15:0] key_b, logic [15:0] key_c);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_entry      <= entry;
      req_key_first  <= key_a;
      req_key_second <= key_b;
      req_key_third  <= key_c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mirror.note_request(action, entry, key_a, key_b, key_c);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_key_count(logic [1:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mirror.key_count = value;
   endtask

   // Mostly tiny values so ties are common, with both extremes and full-range noise.
   function automatic logic [15:0] pick_key();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'h0000;
      if (r < 20) return 16'hFFFF;
      if (r < 35) return 16'($urandom);
      return 16'($urandom_range(0, 3));
   endfunction

   task automatic run_phase(logic [1:0] kc, int unsigned items, int unsigned ins_pct,
                            int unsigned clr_pct, int unsigned gaps, int unsigned stalls);
      int unsigned r;
      logic [1:0]  action;
      write_key_count(kc);
      gap_pct   = gaps;
      stall_pct = stalls;
      repeat (items) begin
         r = $urandom_range(0, 99);
         if (r < clr_pct) action = ACT_CLEAR;
         else if (r < clr_pct + ins_pct) action = ACT_INSERT;
         else if ($urandom_range(0, 2) != 0) action = ACT_REMOVE;
         else action = ACT_PEEK;
         send_req(action, $urandom, pick_key(), pick_key(), pick_key());
         // occasionally hold off until the block has answered everything
         if (!calm && $urandom_range(0, 99) < 2) wait_drained();
      end
   endtask

   initial begin
      #(TIMEOUT_CYCLES * 4);
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue, extremes, ties under three components
      write_key_count(2'd3);
      gap_pct   = 30;
      stall_pct = 30;
      send_req(ACT_REMOVE, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000);
      send_req(ACT_PEEK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_req(ACT_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_req(ACT_INSERT, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000);
      send_req(ACT_INSERT, 32'h1234_5678, 16'd5, 16'd7, 16'd9);
      send_req(ACT_INSERT, 32'hA5A5_A5A5, 16'd5, 16'd7, 16'd9);
      send_req(ACT_INSERT, 32'h5A5A_5A5A, 16'd5, 16'd7, 16'd8);
      send_req(ACT_INSERT, 32'h0000_FFFF, 16'd5, 16'd6, 16'hFFFF);
      send_req(ACT_PEEK, 32'd0, 16'd0, 16'd0, 16'd0);
      send_req(ACT_REMOVE, 32'd0, 16'd0, 16'd0, 16'd0);
      send_req(ACT_REMOVE, 32'd0, 16'd0, 16'd0, 16'd0);
      send_req(ACT_REMOVE, 32'd0, 16'd0, 16'd0, 16'd0);

      // narrow the ordering while entries are stored; unused keys read zero
      write_key_count(2'd1);
      send_req(ACT_PEEK, 32'd0, 16'd0, 16'd0, 16'd0);
      send_req(ACT_INSERT, 32'h0000_0001, 16'd5, 16'd0, 16'd0);
      send_req(ACT_INSERT, 32'h0000_0002, 16'd5, 16'hFFFF, 16'hFFFF);
      send_req(ACT_REMOVE, 32'd0, 16'd0, 16'd0, 16'd0);
      send_req(ACT_REMOVE, 32'd0, 16'd0, 16'd0, 16'd0);
      send_req(ACT_REMOVE, 32'd0, 16'd0, 16'd0, 16'd0);
      send_req(ACT_CLEAR, 32'hDEAD_BEEF, 16'hFFFF, 16'd1, 16'd2);
      send_req(ACT_PEEK, 32'd0, 16'd0, 16'd0, 16'd0);
      send_req(ACT_INSERT, 32'h8000_0001, 16'hFFFF, 16'h0000, 16'h0000);
      send_req(ACT_INSERT, 32'h7FFF_FFFE, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_req(ACT_REMOVE, 32'd0, 16'd0, 16'd0, 16'd0);

      run_phase(2'd2, 150, 60, 2, 30, 30);
      run_phase(2'd3, 150, 90, 0, 20, 50);   // runs into the full queue
      run_phase(2'd0, 130, 30, 1, 0, 0);     // drains to empty, zero acts as one
      run_phase(2'd1, 150, 55, 3, 40, 20);
      run_phase(2'd3, 140, 50, 2, 10, 60);
      calm = 1'b1;
      run_phase(2'd2, 110, 85, 1, 0, 0);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mirror.pending_results.size() != 0)
         mirror.log_failure($sformatf("%0d responses never arrived",
                                      mirror.pending_results.size()));
      if (mirror.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
